### rtl/mims_pkg.sv
// ----------------------------------------------------------------------------
// mims_pkg
// Shared types and constants of the minimum-interval message shaper.
// ----------------------------------------------------------------------------
package mims_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int MSG_ID_W  = 11;
    localparam int NODE_ID_W = 8;
    localparam int LEN_W     = 4;
    localparam int PAYLOAD_W = 64;
    localparam int HEADER_W  = MSG_ID_W + NODE_ID_W + LEN_W;
    localparam int QCOUNT_W  = 5;
    localparam int TIMER_W   = 16;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 96;
    localparam int OUT_TUSER_W = 2;

    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] ADDR_MIN_INTERVAL = '0;

    localparam logic ACT_TICK    = 1'b0;
    localparam logic ACT_MESSAGE = 1'b1;

    typedef struct packed {
        logic [NODE_ID_W-1:0] node_id;
        logic [LEN_W-1:0]     msg_length;
        logic [MSG_ID_W-1:0]  msg_id;
    } t_header;

    // Write and read requests to the queue store
    typedef struct packed {
        logic                 wr_en;
        logic [PTR_W-1:0]     wr_addr;
        t_header              wr_header;
        logic [PAYLOAD_W-1:0] wr_payload;
        logic                 rd_en;
        logic [PTR_W-1:0]     rd_addr;
    } t_mem_req;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

endpackage

### rtl/mims_queue_mem.sv
// ----------------------------------------------------------------------------
// mims_queue_mem
// Message queue store: header and payload arrays, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module mims_queue_mem
    import mims_pkg::*;
(
    input  logic                 i_clk,
    input  t_mem_req             i_req,
    output t_header              o_rd_header,
    output logic [PAYLOAD_W-1:0] o_rd_payload
);

    t_header              r_header_mem  [QUEUE_DEPTH];
    logic [PAYLOAD_W-1:0] r_payload_mem [QUEUE_DEPTH];
    t_header              r_rd_header;
    logic [PAYLOAD_W-1:0] r_rd_payload;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_header_mem[i_req.wr_addr]  <= i_req.wr_header;
            r_payload_mem[i_req.wr_addr] <= i_req.wr_payload;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_header  <= r_header_mem[i_req.rd_addr];
            r_rd_payload <= r_payload_mem[i_req.rd_addr];
        end
    end

    assign o_rd_header  = r_rd_header;
    assign o_rd_payload = r_rd_payload;

endmodule

### rtl/min_interval_message_shaper.sv
// ----------------------------------------------------------------------------
// min_interval_message_shaper
// Enforces a minimum number of ticks between message deliveries, queueing
// messages that arrive too early and dropping them when the queue is full.
// ----------------------------------------------------------------------------
// Every input beat is a tick or a message and yields exactly one output beat
// in the next cycle. A new beat is taken every cycle while the output side
// accepts; the single output register stalls the input when it is full and
// not drained. Queued messages sit in a QUEUE_DEPTH-entry store with
// registered reads: the head entry is read at the edge the beat is taken and
// appears on the output register stage in the next cycle. No clearing pass
// is needed after reset. min_interval sits at byte address 0 of the APB port.
module min_interval_message_shaper
    import mims_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // msg_id[10:0], node_id[18:11], msg_length[22:19], payload[86:23], pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // action: 0 tick, 1 message
    input  logic                   s_axis_tuser,
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_msg_id[10:0], out_node_id[18:11], out_length[22:19],
    // out_payload[86:23], queue_count[91:87], pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // delivered[0], dropped[1]
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    logic [TIMER_W-1:0]   r_min_interval;
    logic                 r_ready_flag, n_ready_flag;
    logic [TIMER_W-1:0]   r_timer, n_timer;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0]     r_count, n_count;

    logic                 r_out_valid;
    logic                 r_delivered, n_delivered;
    logic                 r_from_mem, n_from_mem;
    logic                 r_dropped, n_dropped;
    logic [QCOUNT_W-1:0]  r_qcount;
    t_header              r_dir_header;
    logic [PAYLOAD_W-1:0] r_dir_payload;

    logic                 accept;
    logic                 in_action;
    t_header              in_header;
    logic [PAYLOAD_W-1:0] in_payload;
    logic [TIMER_W-1:0]   reload;
    logic [TIMER_W-1:0]   timer_dec;
    t_mem_req             mem_req;
    t_header              mem_header;
    logic [PAYLOAD_W-1:0] mem_payload;
    t_header              out_header;
    logic [PAYLOAD_W-1:0] out_payload;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_INTERVAL) ? {16'd0, r_min_interval} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= TIMER_W'(1);
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_MIN_INTERVAL) begin
            r_min_interval <= pwdata[TIMER_W-1:0];
        end
    end

    // ---------------- input side ----------------
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_action            = s_axis_tuser;
    assign in_header.msg_id     = s_axis_tdata[10:0];
    assign in_header.node_id    = s_axis_tdata[18:11];
    assign in_header.msg_length = s_axis_tdata[22:19];
    assign in_payload           = s_axis_tdata[86:23];

    assign reload    = (r_min_interval == '0) ? TIMER_W'(1) : r_min_interval;
    assign timer_dec = (r_timer != '0) ? r_timer - TIMER_W'(1) : '0;

    // Every accepted beat reads the head, but a beat that writes an entry never
    // uses that read data, so the store needs no forwarding.
    always_comb begin
        n_ready_flag = r_ready_flag;
        n_timer      = r_timer;
        n_rd_ptr     = r_rd_ptr;
        n_wr_ptr     = r_wr_ptr;
        n_count      = r_count;
        n_delivered  = 1'b0;
        n_from_mem   = 1'b0;
        n_dropped    = 1'b0;

        mem_req.wr_en      = 1'b0;
        mem_req.wr_addr    = r_wr_ptr;
        mem_req.wr_header  = in_header;
        mem_req.wr_payload = in_payload;
        mem_req.rd_en      = accept;
        mem_req.rd_addr    = r_rd_ptr;

        if (accept) begin
            if (in_action == ACT_MESSAGE) begin
                if (r_ready_flag) begin
                    n_ready_flag = 1'b0;
                    n_timer      = reload;
                    n_delivered  = 1'b1;
                end else if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                    n_dropped = 1'b1;
                end else begin
                    mem_req.wr_en = 1'b1;
                    n_wr_ptr      = ptr_inc(r_wr_ptr);
                    n_count       = r_count + CNT_W'(1);
                end
            end else if (!r_ready_flag) begin
                n_timer = timer_dec;
                if (timer_dec == '0) begin
                    if (r_count != '0) begin
                        n_delivered = 1'b1;
                        n_from_mem  = 1'b1;
                        n_rd_ptr    = ptr_inc(r_rd_ptr);
                        n_count     = r_count - CNT_W'(1);
                        n_timer     = reload;
                    end else begin
                        n_ready_flag = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_flag <= 1'b1;
            r_timer      <= '0;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_count      <= '0;
        end else begin
            r_ready_flag <= n_ready_flag;
            r_timer      <= n_timer;
            r_rd_ptr     <= n_rd_ptr;
            r_wr_ptr     <= n_wr_ptr;
            r_count      <= n_count;
        end
    end

    mims_queue_mem u_queue_mem (
        .i_clk        (i_clk),
        .i_req        (mem_req),
        .o_rd_header  (mem_header),
        .o_rd_payload (mem_payload)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_delivered   <= n_delivered;
            r_from_mem    <= n_from_mem;
            r_dropped     <= n_dropped;
            r_qcount      <= QCOUNT_W'(n_count);
            r_dir_header  <= in_header;
            r_dir_payload <= in_payload;
        end
    end

    always_comb begin
        out_header  = '0;
        out_payload = '0;
        if (r_delivered) begin
            out_header  = r_from_mem ? mem_header  : r_dir_header;
            out_payload = r_from_mem ? mem_payload : r_dir_payload;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_qcount, out_payload, out_header.msg_length,
                            out_header.node_id, out_header.msg_id};
    assign m_axis_tuser  = {r_dropped, r_delivered};

endmodule
